// ----- src/mmr_pkg.sv -----
// ============================================================================
// mmr_pkg: shared types and constants for the masked multimode reduction
// Holds the mode codes, register indexes, controller states and the command
// and status bundles passed between the controller and the datapath.
// ============================================================================
package mmr_pkg;

    // Field widths fixed by the item formats.
    localparam int SAMPLE_W  = 32;
    localparam int WEIGHT_W  = 32;
    localparam int MASK_W    = 32;
    localparam int VALUE_W   = 64;
    localparam int POS_OUT_W = 17;
    localparam int CNT_OUT_W = 17;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_ELEMENTS = 65536;
    localparam int DEF_FRAC_BITS    = 16;

    // Configuration port.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_SUBSET = 2'd1;
    localparam logic [1:0] REG_GROUP  = 2'd2;

    // Min and max start from the 64-bit extremes.
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    typedef enum logic [2:0] {
        MODE_SUM   = 3'd0,
        MODE_SUMSQ = 3'd1,
        MODE_MIN   = 3'd2,
        MODE_MAX   = 3'd3,
        MODE_AVE   = 3'd4,
        MODE_AVESQ = 3'd5,
        MODE_WSUM  = 3'd6,
        MODE_WAVE  = 3'd7
    } t_mode;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_FINISH,
        ST_DIVIDE,
        ST_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic accum;
        logic clear;
        logic div_start;
        logic div_step;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic s1_last;
        logic div_needed;
        logic div_busy;
    } t_stat;

endpackage

// ----- src/mmr_if.sv -----
// ============================================================================
// mmr_in_if / mmr_out_if: valid-ready channels of the reduction block
// The input channel carries one sample item, the output channel one result.
// ============================================================================
interface mmr_in_if import mmr_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic [WEIGHT_W-1:0]        weight;
    logic [MASK_W-1:0]          group_mask;
    logic                       last;

    modport source (output valid, sample, weight, group_mask, last, input ready);
    modport sink   (input valid, sample, weight, group_mask, last, output ready);
endinterface

interface mmr_out_if import mmr_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [VALUE_W-1:0]   reduced_value;
    logic signed [POS_OUT_W-1:0] winner_position;
    logic [CNT_OUT_W-1:0]        included_total;

    modport source (output valid, reduced_value, winner_position, included_total,
                    input ready);
    modport sink   (input valid, reduced_value, winner_position, included_total,
                    output ready);
endinterface

// ----- src/mmr_ctrl.sv -----
// ============================================================================
// mmr_ctrl: run controller of the reduction block
// Sequences accumulation, the end-of-run division and the result hand-off.
// ============================================================================
module mmr_ctrl import mmr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_out_ready,
    input  logic  i_cfg_restart,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_in_ready,
    output logic  o_out_valid
);

    t_state r_state;
    t_state n_state;
    logic   r_s1_vld;
    logic   r_out_vld;
    logic   w_in_ready;
    logic   w_out_free;

    assign w_out_free = !r_out_vld || i_out_ready;
    assign w_in_ready = (r_state == ST_RUN) && !(r_s1_vld && i_stat.s1_last);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_RUN: begin
                if (r_s1_vld && i_stat.s1_last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                n_state = i_stat.div_needed ? ST_DIVIDE : ST_EMIT;
            end
            ST_DIVIDE: begin
                if (!i_stat.div_busy) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_state = ST_RUN;
                end
            end
            default: n_state = ST_RUN;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.load_in   = i_in_valid && w_in_ready;
        o_cmd.accum     = r_s1_vld;
        o_cmd.clear     = i_cfg_restart;
        unique case (r_state)
            ST_RUN: begin
            end
            ST_FINISH: begin
                o_cmd.div_start = i_stat.div_needed;
            end
            ST_DIVIDE: begin
                o_cmd.div_step = i_stat.div_busy;
            end
            ST_EMIT: begin
                o_cmd.load_out = w_out_free;
                o_cmd.clear    = w_out_free || i_cfg_restart;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_RUN;
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_s1_vld <= o_cmd.load_in;
            if (o_cmd.load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_in_ready  = w_in_ready;
    assign o_out_valid = r_out_vld;

endmodule

// ----- src/mmr_datapath.sv -----
// ============================================================================
// mmr_datapath: arithmetic of the reduction block
// Multiplier stage, saturating accumulator, run counters, a bit-serial
// restoring divider for the averages, and the result register.
// ============================================================================
module mmr_datapath import mmr_pkg::*; #(
    parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
    parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cmd                        i_cmd,
    output t_stat                       o_stat,
    input  t_mode                       i_mode,
    input  t_mode                       i_start_mode,
    input  logic                        i_subset_en,
    input  logic [MASK_W-1:0]           i_group_bits,
    input  logic signed [SAMPLE_W-1:0]  i_sample,
    input  logic [WEIGHT_W-1:0]         i_weight,
    input  logic [MASK_W-1:0]           i_group_mask,
    input  logic                        i_last,
    output logic signed [VALUE_W-1:0]   o_reduced_value,
    output logic signed [POS_OUT_W-1:0] o_winner_position,
    output logic [CNT_OUT_W-1:0]        o_included_total
);

    localparam int POS_W  = $clog2(MAX_ELEMENTS);
    localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
    localparam int QUO_W  = VALUE_W + FRAC_BITS;
    localparam int STEP_W = $clog2(QUO_W + 1);
    localparam logic [POS_W-1:0]   POS_LAST  = POS_W'(MAX_ELEMENTS - 1);
    localparam logic [CNT_W-1:0]   CNT_MAX   = CNT_W'(MAX_ELEMENTS);
    localparam logic [VALUE_W-1:0] FRAC_MASK = (VALUE_W'(1) << FRAC_BITS) - VALUE_W'(1);
    localparam logic [QUO_W-1:0]   LIM_POS   = QUO_W'(VALUE_MAX);
    localparam logic [QUO_W-1:0]   LIM_NEG   = QUO_W'($unsigned(VALUE_MIN));

    // Stage one: registered item and product.
    logic signed [SAMPLE_W-1:0] r_s1_smp;
    logic [WEIGHT_W-1:0]        r_s1_w;
    logic [VALUE_W-1:0]         r_s1_prod;
    logic                       r_s1_incl;
    logic                       r_s1_last;

    // Run state.
    logic signed [VALUE_W-1:0]  r_acc;
    logic                       r_best_vld;
    logic [POS_W-1:0]           r_best;
    logic [POS_W-1:0]           r_pos;
    logic [CNT_W-1:0]           r_cnt;
    logic [VALUE_W-1:0]         r_wt;

    // Divider.
    logic [VALUE_W-1:0]         r_rem;
    logic [QUO_W-1:0]           r_quo;
    logic [STEP_W-1:0]          r_div_cnt;

    // Result register.
    logic signed [VALUE_W-1:0]   r_out_value;
    logic signed [POS_OUT_W-1:0] r_out_winner;
    logic [CNT_OUT_W-1:0]        r_out_total;

    logic signed [SAMPLE_W:0]   w_mul_b;
    logic signed [SAMPLE_W*2:0] w_prod;
    logic signed [VALUE_W-1:0]  w_addend;
    logic                       w_carry;
    logic signed [VALUE_W+1:0]  w_sum;
    logic signed [VALUE_W-1:0]  w_sat;
    logic signed [VALUE_W-1:0]  w_smp64;
    logic                       w_less;
    logic                       w_more;
    logic [VALUE_W:0]           w_wsum;
    logic [VALUE_W-1:0]         w_mag;
    logic [VALUE_W-1:0]         w_divisor;
    logic [QUO_W-1:0]           w_dvd_init;
    logic [VALUE_W:0]           w_rem_sh;
    logic [VALUE_W:0]           w_rem_sub;
    logic                       w_ge;
    logic [QUO_W-1:0]           w_lim;
    logic [VALUE_W-1:0]         w_clamp;
    logic [VALUE_W-1:0]         w_qval;
    logic                       w_div_needed;
    logic signed [VALUE_W-1:0]  w_result;
    logic [31:0]                w_best32;
    logic [31:0]                w_cnt32;

    // One multiplier serves both the square and the weighted term.
    assign w_mul_b = ((i_mode == MODE_SUMSQ) || (i_mode == MODE_AVESQ))
                   ? (SAMPLE_W+1)'(i_sample) : $signed({1'b0, i_weight});
    assign w_prod  = (SAMPLE_W*2+1)'(i_sample) * (SAMPLE_W*2+1)'(w_mul_b);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_s1_smp  <= i_sample;
            r_s1_w    <= i_weight;
            r_s1_prod <= w_prod[VALUE_W-1:0];
            r_s1_incl <= !i_subset_en || ((i_group_mask & i_group_bits) != '0);
            r_s1_last <= i_last;
        end
    end

    // Weighted terms truncate toward zero: arithmetic shift, plus one when a
    // negative product drops nonzero fraction bits.
    always_comb begin
        w_addend = VALUE_W'(r_s1_smp);
        w_carry  = 1'b0;
        case (i_mode) inside
            MODE_SUMSQ, MODE_AVESQ: begin
                w_addend = r_s1_prod >> FRAC_BITS;
            end
            MODE_WSUM, MODE_WAVE: begin
                w_addend = $signed(r_s1_prod) >>> FRAC_BITS;
                w_carry  = r_s1_prod[VALUE_W-1] && ((r_s1_prod & FRAC_MASK) != '0);
            end
            default: begin
                w_addend = VALUE_W'(r_s1_smp);
            end
        endcase
    end

    assign w_sum   = (VALUE_W+2)'(r_acc) + (VALUE_W+2)'(w_addend)
                   + (VALUE_W+2)'({1'b0, w_carry});
    assign w_sat   = (w_sum[VALUE_W+1:VALUE_W-1] == 3'b000 ||
                      w_sum[VALUE_W+1:VALUE_W-1] == 3'b111)
                   ? w_sum[VALUE_W-1:0] : (w_sum[VALUE_W+1] ? VALUE_MIN : VALUE_MAX);
    assign w_smp64 = VALUE_W'(r_s1_smp);
    assign w_less  = w_smp64 < r_acc;
    assign w_more  = w_smp64 > r_acc;
    assign w_wsum  = {1'b0, r_wt} + (VALUE_W+1)'(r_s1_w);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_best_vld <= 1'b0;
            r_best     <= '0;
            r_pos      <= '0;
            r_cnt      <= '0;
            r_wt       <= '0;
        end else if (i_cmd.clear) begin
            case (i_start_mode)
                MODE_MIN: r_acc <= VALUE_MAX;
                MODE_MAX: r_acc <= VALUE_MIN;
                default:  r_acc <= '0;
            endcase
            r_best_vld <= 1'b0;
            r_pos      <= '0;
            r_cnt      <= '0;
            r_wt       <= '0;
        end else if (i_cmd.accum) begin
            if (r_s1_incl) begin
                if (r_cnt != CNT_MAX) begin
                    r_cnt <= r_cnt + 1'b1;
                end
                case (i_mode)
                    MODE_MIN: begin
                        if (w_less) begin
                            r_acc      <= w_smp64;
                            r_best_vld <= 1'b1;
                            r_best     <= r_pos;
                        end
                    end
                    MODE_MAX: begin
                        if (w_more) begin
                            r_acc      <= w_smp64;
                            r_best_vld <= 1'b1;
                            r_best     <= r_pos;
                        end
                    end
                    default: r_acc <= w_sat;
                endcase
                r_wt <= w_wsum[VALUE_W] ? '1 : w_wsum[VALUE_W-1:0];
            end
            if (r_pos != POS_LAST) begin
                r_pos <= r_pos + 1'b1;
            end
        end
    end

    // Restoring division of the accumulator magnitude, one quotient bit per
    // cycle. The weighted average scales the dividend by 2^FRAC_BITS.
    assign w_mag      = r_acc[VALUE_W-1] ? (VALUE_W'(0) - $unsigned(r_acc)) : $unsigned(r_acc);
    assign w_divisor  = (i_mode == MODE_WAVE) ? r_wt : VALUE_W'(r_cnt);
    assign w_dvd_init = (i_mode == MODE_WAVE) ? (QUO_W'(w_mag) << FRAC_BITS) : QUO_W'(w_mag);
    assign w_rem_sh   = {r_rem, r_quo[QUO_W-1]};
    assign w_ge       = w_rem_sh >= {1'b0, w_divisor};
    assign w_rem_sub  = w_rem_sh - {1'b0, w_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_start) begin
            r_div_cnt <= STEP_W'(QUO_W);
        end else if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_quo <= w_dvd_init;
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_rem_sub[VALUE_W-1:0] : w_rem_sh[VALUE_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], w_ge};
        end
    end

    assign w_lim   = r_acc[VALUE_W-1] ? LIM_NEG : LIM_POS;
    assign w_clamp = (r_quo > w_lim) ? w_lim[VALUE_W-1:0] : r_quo[VALUE_W-1:0];
    assign w_qval  = r_acc[VALUE_W-1] ? (VALUE_W'(0) - w_clamp) : w_clamp;

    assign w_div_needed = (((i_mode == MODE_AVE) || (i_mode == MODE_AVESQ)) && (r_cnt != '0))
                       || ((i_mode == MODE_WAVE) && (r_wt != '0));
    assign w_result = w_div_needed ? $signed(w_qval) : r_acc;
    assign w_best32 = 32'(r_best);
    assign w_cnt32  = 32'(r_cnt);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_value <= w_result;
            if (((i_mode == MODE_MIN) || (i_mode == MODE_MAX)) && r_best_vld) begin
                r_out_winner <= w_best32[POS_OUT_W-1:0];
            end else begin
                r_out_winner <= '1;
            end
            r_out_total <= w_cnt32[CNT_OUT_W-1:0];
        end
    end

    assign o_stat.s1_last    = r_s1_last;
    assign o_stat.div_needed = w_div_needed;
    assign o_stat.div_busy   = (r_div_cnt != '0);

    assign o_reduced_value   = r_out_value;
    assign o_winner_position = r_out_winner;
    assign o_included_total  = r_out_total;

endmodule

// ----- src/masked_multimode_reduction.sv -----
// ============================================================================
// masked_multimode_reduction: streaming sum/min/max/average reduction
// Reduces runs of fixed-point samples, one result item per run.
// ============================================================================
// The block reduces a run of signed fixed-point samples (FRAC_BITS fraction
// bits) that ends with the item carrying the last mark, and emits one result
// item per run: sum, sum of squares, min, max, average, average of squares,
// weighted sum or weighted average, chosen by the mode register. With
// subset_enable set, only items whose group_mask shares a bit with group_bits
// are reduced, but every item still takes a position. Within a run the block
// takes one item per clock cycle: a multiplier stage feeds a saturating
// 64-bit accumulator. After the last item, the controller closes the run
// in its finish and emit states; the averages (when the divisor is nonzero)
// pass through its divide state between them, where the bit-serial restoring
// divider takes one quotient bit per cycle until it finishes. No item is
// taken after the last item of a run until its result sits in the output
// register; a finished result waits there while the next run streams in.
// Writing the mode register restarts the run; configure only while the block
// is idle.
// ============================================================================
module masked_multimode_reduction import mmr_pkg::*; #(
    parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
    parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mmr_in_if.sink                i_in,
    mmr_out_if.source             o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_mode             r_mode;
    logic              r_subset;
    logic [MASK_W-1:0] r_group;

    logic        w_wr;
    logic        w_mode_wr;
    logic [1:0]  w_idx;
    t_mode       w_start_mode;
    t_cmd        w_cmd;
    t_stat       w_stat;

    // Configuration registers. A mode write also restarts the run, and the
    // restart already uses the new mode for the start value.
    assign pready       = 1'b1;
    assign w_idx        = paddr[3:2];
    assign w_wr         = psel && penable && pwrite && pready;
    assign w_mode_wr    = w_wr && (w_idx == REG_MODE);
    assign w_start_mode = w_mode_wr ? t_mode'(pwdata[2:0]) : r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_SUM;
            r_subset <= 1'b0;
            r_group  <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_MODE:   r_mode   <= t_mode'(pwdata[2:0]);
                REG_SUBSET: r_subset <= pwdata[0];
                REG_GROUP:  r_group  <= pwdata[MASK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_MODE:   prdata = APB_DATA_W'(r_mode);
            REG_SUBSET: prdata = APB_DATA_W'(r_subset);
            REG_GROUP:  prdata = APB_DATA_W'(r_group);
            default:    prdata = '0;
        endcase
    end

    // The controller decides when items enter, when the run closes and when
    // the result register loads; the datapath does the arithmetic.
    mmr_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in.valid),
        .i_out_ready   (o_out.ready),
        .i_cfg_restart (w_mode_wr),
        .i_stat        (w_stat),
        .o_cmd         (w_cmd),
        .o_in_ready    (i_in.ready),
        .o_out_valid   (o_out.valid)
    );

    mmr_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_mode            (r_mode),
        .i_start_mode      (w_start_mode),
        .i_subset_en       (r_subset),
        .i_group_bits      (r_group),
        .i_sample          (i_in.sample),
        .i_weight          (i_in.weight),
        .i_group_mask      (i_in.group_mask),
        .i_last            (i_in.last),
        .o_reduced_value   (o_out.reduced_value),
        .o_winner_position (o_out.winner_position),
        .o_included_total  (o_out.included_total)
    );

    // The divider owns the run state while it works, so no item may enter.
    a_no_input_while_dividing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_stat.div_busy |-> !i_in.ready
    ) else $error("input accepted while the divider is busy");

    // Once the last item of a run is taken, the next run must wait.
    a_stall_after_last: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.last) |=> !i_in.ready
    ) else $error("item accepted right after the last item of a run");

    // Only min and max report a winner position.
    a_winner_only_min_max: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (r_mode != MODE_MIN) && (r_mode != MODE_MAX))
            |-> (o_out.winner_position == '1)
    ) else $error("winner position reported outside min and max modes");

endmodule
